>>> hdl/curvature_tensor_to_quartic_direction_assert.svh
// ---------------------------------------------------------------------------
// curvature_tensor_to_quartic_direction_assert
// Assertion macros for the quartic direction block.
// ---------------------------------------------------------------------------
`ifndef CURVATURE_TENSOR_TO_QUARTIC_DIRECTION_ASSERT_SVH
`define CURVATURE_TENSOR_TO_QUARTIC_DIRECTION_ASSERT_SVH
// Property p must hold on every clock edge out of reset.
`define CTQD_ASSERT(label, p, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (p)) else $error(msg);
// A condition a implies b in the next cycle.
`define CTQD_ASSERT_NEXT(label, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) else $error(msg);
`endif

>>> hdl/ctqd_pkg.sv
// ---------------------------------------------------------------------------
// ctqd_pkg
// Shared constants and cell payload type for the quartic direction block.
// ---------------------------------------------------------------------------
package ctqd_pkg;
	localparam int DevWidth  = 33;  // |x|, |y| magnitudes
	localparam int SqWidth   = 67;  // x^2 + y^2
	localparam int RootBits  = 34;  // root bits 33..0
	localparam int QFrac     = 14;
	localparam int QBits     = QFrac + 1;  // quotient bits 14..0
	localparam int NumCells  = RootBits + QBits;
	localparam int RootIdxW  = $clog2(RootBits);
	localparam int QIdxW     = $clog2(QBits);
	localparam logic [31:0] MinAnisoReset = 32'd1;

	// Payload that walks the chain of cells.
	typedef struct packed {
		logic                valid;   // deviator above threshold
		logic [SqWidth-1:0]  s;       // x^2 + y^2
		logic [SqWidth-1:0]  rem_r;   // square root remainder
		logic [RootBits-1:0] root;
		logic [SqWidth+QFrac:0] rem_re; // divider remainders
		logic [SqWidth+QFrac:0] rem_im;
		logic [QBits-1:0]    q_re;
		logic [QBits-1:0]    q_im;
		logic                neg_re;
		logic                neg_im;
		logic [DevWidth-1:0] atr;
	} cell_t;
endpackage

>>> hdl/ctqd_stream_if.sv
// ---------------------------------------------------------------------------
// ctqd_stream_if
// Valid/ready channels for the input entries, the results and the configuration.
// ---------------------------------------------------------------------------
interface ctqd_in_if;
	logic valid;
	logic ready;
	logic signed [31:0] entry_00;
	logic signed [31:0] entry_01;
	logic signed [31:0] entry_10;
	logic signed [31:0] entry_11;
	modport source (output valid, entry_00, entry_01, entry_10, entry_11, input ready);
	modport sink (input valid, entry_00, entry_01, entry_10, entry_11, output ready);
endinterface

interface ctqd_out_if;
	logic valid;
	logic ready;
	logic signed [15:0] quartic_real;
	logic signed [15:0] quartic_imag;
	logic [32:0] anisotropy;
	logic [32:0] magnitude;
	logic valid_res;
	modport source (output valid, quartic_real, quartic_imag, anisotropy, magnitude,
		valid_res, input ready);
	modport sink (input valid, quartic_real, quartic_imag, anisotropy, magnitude,
		valid_res, output ready);
endinterface

interface ctqd_cfg_if;
	logic valid;
	logic ready;
	logic [31:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

>>> hdl/curvature_tensor_to_quartic_direction.sv
// A beat passes stages 1 to 3, the root cells, the divide cells and the output register.
// Throughput: one item per cycle; a chain of 34 root cells and 15 divide
// cells, one bit each, sets the depth. Output stalls hold the whole chain.
// Reset: arst_n clears the beat valid bits and sets min_anisotropy to 1.
// ---------------------------------------------------------------------------
// curvature_tensor_to_quartic_direction
// Quartic direction, anisotropy and magnitude of a 2x2 shape operator.
// ---------------------------------------------------------------------------
`include "curvature_tensor_to_quartic_direction_assert.svh"
module curvature_tensor_to_quartic_direction (
	input logic clk,
	input logic arst_n,
	ctqd_in_if.sink     in_ch,
	ctqd_cfg_if.sink    cfg,
	ctqd_out_if.source  out_ch
);
	localparam int DW = ctqd_pkg::DevWidth;
	localparam int SW = ctqd_pkg::SqWidth;
	localparam int RW = ctqd_pkg::SqWidth + ctqd_pkg::QFrac + 1;
	localparam int Stages = 3 + ctqd_pkg::NumCells;

	logic [31:0] min_aniso_q;
	logic        adv;
	logic [Stages:0] vld_q;

	// Pipeline advances whenever the output register is free or drained.
	assign adv = !vld_q[Stages] || out_ch.ready;
	assign in_ch.ready = adv;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_aniso_q <= ctqd_pkg::MinAnisoReset;
		end else if (cfg.valid) begin
			min_aniso_q <= cfg.data;
		end
	end

	// Beat valid bits down the chain.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[Stages-1:0], in_ch.valid};
		end
	end

	// Stage 1: deviator and trace.
	logic signed [DW-1:0] x_s1, y_s1, tr_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1  <= DW'(in_ch.entry_00) - DW'(in_ch.entry_11);
			y_s1  <= DW'(in_ch.entry_01) + DW'(in_ch.entry_10);
			tr_s1 <= DW'(in_ch.entry_00) + DW'(in_ch.entry_11);
		end
	end

	// Stage 2: magnitudes and squares.
	logic [DW-1:0] ax, ay;
	logic [DW-1:0] ax_s2, ay_s2, atr_s2;
	logic [SW-1:0] xx_s2, yy_s2, xy_s2;
	logic [63:0]   th_s2;
	logic          nx_s2, ny_s2;
	assign ax = x_s1[DW-1] ? DW'(-x_s1) : DW'(x_s1);
	assign ay = y_s1[DW-1] ? DW'(-y_s1) : DW'(y_s1);
	always_ff @(posedge clk) begin
		if (adv) begin
			ax_s2  <= ax;
			ay_s2  <= ay;
			atr_s2 <= tr_s1[DW-1] ? DW'(-tr_s1) : DW'(tr_s1);
			xx_s2  <= SW'(ax) * SW'(ax);
			yy_s2  <= SW'(ay) * SW'(ay);
			xy_s2  <= SW'(ax) * SW'(ay);
			th_s2  <= 64'(min_aniso_q) * 64'(min_aniso_q);
			nx_s2  <= x_s1[DW-1];
			ny_s2  <= y_s1[DW-1];
		end
	end

	// Stage 3: sum, threshold, divider numerators.
	ctqd_pkg::cell_t c3;
	ctqd_pkg::cell_t chain [ctqd_pkg::NumCells+1];
	logic [SW-1:0] s2;
	assign s2 = xx_s2 + yy_s2;
	always_ff @(posedge clk) begin
		if (adv) begin
			c3.valid  <= s2 > SW'(th_s2);
			c3.s      <= s2;
			c3.rem_r  <= s2;
			c3.root   <= '0;
			c3.rem_re <= (xx_s2 >= yy_s2) ? RW'(xx_s2 - yy_s2) << ctqd_pkg::QFrac
				: RW'(yy_s2 - xx_s2) << ctqd_pkg::QFrac;
			c3.rem_im <= RW'({xy_s2[SW-2:0], 1'b0}) << ctqd_pkg::QFrac;
			c3.q_re   <= '0;
			c3.q_im   <= '0;
			c3.neg_re <= xx_s2 < yy_s2;
			c3.neg_im <= nx_s2 != ny_s2;
			c3.atr    <= atr_s2;
		end
	end
	assign chain[0] = c3;

	// Chain of root cells, then divider cells.
	for (genvar i = 0; i < ctqd_pkg::RootBits; i++) begin : g_root
		ctqd_root_cell u_cell (
			.clk(clk), .en(adv),
			.bit_pos(ctqd_pkg::RootIdxW'(ctqd_pkg::RootBits - 1 - i)),
			.d(chain[i]), .q(chain[i+1]));
	end
	for (genvar i = 0; i < ctqd_pkg::QBits; i++) begin : g_div
		ctqd_div_cell u_cell (
			.clk(clk), .en(adv),
			.bit_pos(ctqd_pkg::QIdxW'(ctqd_pkg::QBits - 1 - i)),
			.d(chain[ctqd_pkg::RootBits+i]),
			.q(chain[ctqd_pkg::RootBits+i+1]));
	end

	// Output stage: round, sign, select.
	ctqd_pkg::cell_t last;
	logic [ctqd_pkg::RootBits-1:0] r_rnd;
	logic [ctqd_pkg::QBits:0] re_rnd, im_rnd;
	logic [DW-1:0] mag;
	assign last = chain[ctqd_pkg::NumCells];
	assign r_rnd = (last.rem_r > SW'(last.root)) ? last.root + 1'b1 : last.root;
	assign re_rnd = {1'b0, last.q_re} + ((last.rem_re << 1) >= RW'(last.s) ? 1'b1 : 1'b0);
	assign im_rnd = {1'b0, last.q_im} + ((last.rem_im << 1) >= RW'(last.s) ? 1'b1 : 1'b0);
	assign mag = (last.atr > DW'(r_rnd)) ? last.atr : DW'(r_rnd);
	always_ff @(posedge clk) begin
		if (adv) begin
			out_ch.quartic_real <= !last.valid ? '0
				: last.neg_re ? -16'(re_rnd) : 16'(re_rnd);
			out_ch.quartic_imag <= !last.valid ? '0
				: last.neg_im ? -16'(im_rnd) : 16'(im_rnd);
			out_ch.anisotropy <= last.valid ? DW'(r_rnd) : '0;
			out_ch.magnitude  <= last.valid ? mag : '0;
			out_ch.valid_res  <= last.valid;
		end
	end
	assign out_ch.valid = vld_q[Stages];

	`CTQD_ASSERT(a_stall_hold, !(out_ch.valid && !out_ch.ready) || !in_ch.ready,
		"input accepted while output stalled")
	`CTQD_ASSERT(a_res_zero, !(out_ch.valid && !out_ch.valid_res) || out_ch.anisotropy == '0,
		"invalid result carries anisotropy")
	`CTQD_ASSERT_NEXT(a_drain, out_ch.valid && out_ch.ready && !vld_q[Stages-1], !out_ch.valid,
		"result repeated")
endmodule

>>> hdl/ctqd_root_cell.sv
// ---------------------------------------------------------------------------
// ctqd_root_cell
// One restoring square root step: settle one root bit, register the beat.
// ---------------------------------------------------------------------------
module ctqd_root_cell (
	input  logic                          clk,
	input  logic                          en,
	input  logic [ctqd_pkg::RootIdxW-1:0] bit_pos,
	input  ctqd_pkg::cell_t               d,
	output ctqd_pkg::cell_t               q
);
	localparam int W = ctqd_pkg::SqWidth;
	logic [W+1:0] trial;
	logic [W+1:0] rem_ext;
	ctqd_pkg::cell_t nxt;

	// Trial subtract (2*root + 2^bit) * 2^bit from the remainder.
	always_comb begin
		nxt = d;
		rem_ext = {2'b00, d.rem_r};
		trial = ({{(W+2-ctqd_pkg::RootBits){1'b0}}, d.root} << (bit_pos + 1))
			+ ((W+2)'(1) << (2 * bit_pos));
		if (trial <= rem_ext) begin
			nxt.rem_r = W'(rem_ext - trial);
			nxt.root = d.root | (ctqd_pkg::RootBits'(1) << bit_pos);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end
endmodule

>>> hdl/ctqd_div_cell.sv
// ---------------------------------------------------------------------------
// ctqd_div_cell
// One restoring divide step on both quartic parts against x^2 + y^2.
// ---------------------------------------------------------------------------
module ctqd_div_cell (
	input  logic                       clk,
	input  logic                       en,
	input  logic [ctqd_pkg::QIdxW-1:0] bit_pos,
	input  ctqd_pkg::cell_t            d,
	output ctqd_pkg::cell_t            q
);
	localparam int RW = ctqd_pkg::SqWidth + ctqd_pkg::QFrac + 1;
	logic [RW-1:0] sd;
	ctqd_pkg::cell_t nxt;

	// Compare shifted divisor with each remainder, subtract on fit.
	always_comb begin
		nxt = d;
		sd = {{(RW-ctqd_pkg::SqWidth){1'b0}}, d.s} << bit_pos;
		if (sd <= d.rem_re) begin
			nxt.rem_re = d.rem_re - sd;
			nxt.q_re = d.q_re | (ctqd_pkg::QBits'(1) << bit_pos);
		end
		if (sd <= d.rem_im) begin
			nxt.rem_im = d.rem_im - sd;
			nxt.q_im = d.q_im | (ctqd_pkg::QBits'(1) << bit_pos);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end
endmodule
